/* rtl/aws_pkg.sv */
// Shared types and constants for the acoustic wave stencil step block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package aws_pkg;

    localparam int GRID_COLS_W = 10;
    localparam int GRID_ROWS_W = 16;
    localparam int MARGIN_W    = 6;
    localparam int GAIN_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int ROUND_SHIFT = 40;
    localparam int MUL_STEPS   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_COL  = 3'd4;

    // Controller to datapath commands.
    // mul_sel: [2] column term, [1] upper coefficient half, [0] upper laplacian half
    typedef struct packed {
        logic       latch;
        logic       mem_rd;
        logic       mem_wr;
        logic       coef_en;
        logic       acc_clr;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_en;
        logic       fin_en;
        logic       res_zero;
    } cmd_t;

endpackage
`default_nettype wire

/* rtl/aws_ctrl.sv */
// Sequencer for the stencil step: raster position, border test and output handshake.
// Depends on aws_pkg; drives the datapath through cmd_t.
`default_nettype none
module aws_ctrl #(
    parameter int MAX_COLS = 512
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic                                   m_tuser,
    input  wire logic [aws_pkg::GRID_COLS_W-1:0]   grid_cols,
    input  wire logic [aws_pkg::GRID_ROWS_W-1:0]   grid_rows,
    input  wire logic [aws_pkg::MARGIN_W-1:0]      border_margin,
    output aws_pkg::cmd_t                          cmd,
    output logic [$clog2(MAX_COLS)-1:0]            col_addr
);
    import aws_pkg::*;

    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int XW     = (CNT_W > GRID_COLS_W) ? CNT_W : GRID_COLS_W;
    localparam int RW     = GRID_ROWS_W + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_LAP  = 3'd2;
    localparam logic [2:0] ST_COEF = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_OUT2 = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [3:0]             step_reg, step_next;
    logic [CNT_W-1:0]       col_reg, col_next;
    logic [GRID_ROWS_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0]      cur_col_reg;
    logic                   inside_reg, last_row_reg, first_row_reg, eog_reg;

    logic [XW-1:0]          gc, cols_eff, c0, c1;
    logic [GRID_ROWS_W-1:0] rows_eff;
    logic [MARGIN_W-1:0]    m_eff;
    logic [RW-1:0]          r0, r1, er, rows_x, m_r;
    logic [XW:0]            m_c;
    logic                   stale_col, accept, inside_now;

    assign gc       = XW'(grid_cols);
    assign cols_eff = (gc < XW'(3)) ? XW'(3) : ((gc > XW'(MAX_COLS)) ? XW'(MAX_COLS) : gc);
    assign rows_eff = (grid_rows < GRID_ROWS_W'(3)) ? GRID_ROWS_W'(3) : grid_rows;
    assign m_eff    = (border_margin == '0) ? MARGIN_W'(1) : border_margin;
    assign rows_x   = RW'(rows_eff);
    assign m_r      = RW'(m_eff);
    assign m_c      = (XW + 1)'(m_eff);

    // Wrap a position left stale by a geometry change before using it.
    assign stale_col = XW'(col_reg) >= cols_eff;
    assign c0 = stale_col ? '0 : XW'(col_reg);
    always_comb
    begin
        r0 = stale_col ? RW'(row_reg) + RW'(1) : RW'(row_reg);
        if (r0 >= rows_x)
        begin
            r0 = '0;
        end
    end
    assign er = r0 - RW'(1);
    assign inside_now = (r0 != '0) && (er >= m_r) && (er + m_r < rows_x)
                        && ((XW + 1)'(c0) >= m_c) && ((XW + 1)'(c0) + m_c < (XW + 1)'(cols_eff));

    assign c1 = c0 + XW'(1);
    assign r1 = r0 + RW'(1);
    always_comb
    begin
        col_next = CNT_W'(c1);
        row_next = GRID_ROWS_W'(r0);
        if (c1 >= cols_eff)
        begin
            col_next = '0;
            row_next = (r1 >= rows_x) ? '0 : GRID_ROWS_W'(r1);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tready && s_tvalid;
    assign m_tvalid = (state_reg == ST_OUT) || (state_reg == ST_OUT2);
    assign m_tuser  = (state_reg == ST_OUT2) && eog_reg;
    assign col_addr = cur_col_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_LAP;
            end
            ST_LAP:
            begin
                cmd.mem_wr = 1'b1;
                if (first_row_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (inside_reg)
                begin
                    state_next = ST_COEF;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_COEF:
            begin
                cmd.coef_en = 1'b1;
                cmd.acc_clr = 1'b1;
                step_next   = '0;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                // Product of step n lands in the accumulator at step n+1.
                cmd.mul_en  = (step_reg < 4'(MUL_STEPS));
                cmd.mul_sel = step_reg[2:0];
                cmd.acc_en  = (step_reg != '0);
                step_next   = step_reg + 4'd1;
                if (step_reg == 4'(MUL_STEPS))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.fin_en   = 1'b1;
                cmd.res_zero = !inside_reg;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (last_row_reg)
                    begin
                        cmd.fin_en   = 1'b1;
                        cmd.res_zero = 1'b1;
                        state_next   = ST_OUT2;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT2:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cur_col_reg   <= '0;
            inside_reg    <= 1'b0;
            last_row_reg  <= 1'b0;
            first_row_reg <= 1'b0;
            eog_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                cur_col_reg   <= ADDR_W'(c0);
                inside_reg    <= inside_now;
                first_row_reg <= (r0 == '0);
                last_row_reg  <= (r0 == rows_x - RW'(1));
                eog_reg       <= (c0 == cols_eff - XW'(1));
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/aws_dp.sv */
// Datapath for the stencil step: line buffers, laplacians, shared multiplier and rounding.
// Depends on aws_pkg; sequenced by aws_ctrl through cmd_t.
`default_nettype none
module aws_dp #(
    parameter int MAX_COLS      = 512,
    parameter int PRESSURE_BITS = 32,
    parameter int VELOCITY_BITS = 13
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire aws_pkg::cmd_t                  cmd,
    input  wire logic [$clog2(MAX_COLS)-1:0]    col_addr,
    input  wire logic [PRESSURE_BITS-1:0]       cur_pressure,
    input  wire logic [PRESSURE_BITS-1:0]       old_pressure,
    input  wire logic [VELOCITY_BITS-1:0]       velocity,
    input  wire logic [PRESSURE_BITS-1:0]       source_term,
    input  wire logic [aws_pkg::GAIN_W-1:0]     gain_row,
    input  wire logic [aws_pkg::GAIN_W-1:0]     gain_col,
    output logic [PRESSURE_BITS-1:0]            new_pressure
);
    import aws_pkg::*;

    localparam int P      = PRESSURE_BITS;
    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int LW     = P + 2;
    localparam int MW     = P + 2;
    localparam int V2W    = 2 * VELOCITY_BITS;
    localparam int CW     = V2W + GAIN_W;
    localparam int AH     = (CW + 1) / 2;
    localparam int BH     = (MW + 1) / 2;
    localparam int PW     = AH + BH;
    localparam int AW     = CW + MW + 2;
    localparam int RNW    = AW - ROUND_SHIFT;
    localparam int TW     = RNW + 2;

    logic [P-1:0]             ctr_mem [MAX_COLS];
    logic [P-1:0]             above_mem [MAX_COLS];
    logic [P-1:0]             old_mem [MAX_COLS];
    logic [VELOCITY_BITS-1:0] vel_mem [MAX_COLS];
    logic [P-1:0]             src_mem [MAX_COLS];

    logic signed [P-1:0]      cur_reg, old_in_reg, src_in_reg;
    logic [VELOCITY_BITS-1:0] vel_in_reg;
    logic signed [P-1:0]      up_q, ctr_q, right_q, o_q, s_q, left_reg;
    logic [VELOCITY_BITS-1:0] v_q;
    logic [MW-1:0]            mag_r_reg, mag_c_reg;
    logic                     sgn_r_reg, sgn_c_reg;
    logic [V2W-1:0]           v2_reg;
    logic [CW-1:0]            coef_r_reg, coef_c_reg;
    logic [PW-1:0]            prod_reg;
    logic [2:0]               psel_reg;
    logic [AW-1:0]            acc_reg;
    logic [P-1:0]             res_reg;

    logic signed [LW-1:0]     lap_r, lap_c, nlap_r, nlap_c;
    logic [ADDR_W-1:0]        addr_right;
    logic [CW-1:0]            coef_sel;
    logic [MW-1:0]            mag_sel;
    logic [AH-1:0]            a_chunk;
    logic [BH-1:0]            b_chunk;
    logic [AW-1:0]            pp_shift, rsum;
    logic                     pp_neg;
    logic signed [RNW-1:0]    rnd;
    logic signed [TW-1:0]     total;
    logic [P-1:0]             sat;

    assign addr_right = col_addr + ADDR_W'(1);

    assign lap_r  = LW'(left_reg) + LW'(right_q) - (LW'(ctr_q) <<< 1);
    assign lap_c  = LW'(up_q) + LW'(cur_reg) - (LW'(ctr_q) <<< 1);
    assign nlap_r = -lap_r;
    assign nlap_c = -lap_c;

    // Partial products: coefficient half times laplacian-magnitude half.
    assign coef_sel = cmd.mul_sel[2] ? coef_c_reg : coef_r_reg;
    assign mag_sel  = cmd.mul_sel[2] ? mag_c_reg : mag_r_reg;
    assign a_chunk  = cmd.mul_sel[1] ? AH'(coef_sel >> AH) : coef_sel[AH-1:0];
    assign b_chunk  = cmd.mul_sel[0] ? BH'(mag_sel >> BH) : mag_sel[BH-1:0];

    always_comb
    begin
        pp_shift = AW'(prod_reg);
        if (psel_reg[1])
        begin
            pp_shift = pp_shift << AH;
        end
        if (psel_reg[0])
        begin
            pp_shift = pp_shift << BH;
        end
    end
    assign pp_neg = psel_reg[2] ? sgn_c_reg : sgn_r_reg;

    // Round half up at the Q.40 point, then add the explicit terms and saturate.
    assign rsum  = acc_reg + (AW'(1) << (ROUND_SHIFT - 1));
    assign rnd   = $signed(rsum[AW-1:ROUND_SHIFT]);
    assign total = TW'(rnd) + (TW'(ctr_q) <<< 1) - TW'(o_q) + TW'(s_q);
    always_comb
    begin
        if (total > TW'($signed({1'b0, {(P - 1){1'b1}}})))
        begin
            sat = {1'b0, {(P - 1){1'b1}}};
        end
        else if (total < TW'($signed({1'b1, {(P - 1){1'b0}}})))
        begin
            sat = {1'b1, {(P - 1){1'b0}}};
        end
        else
        begin
            sat = total[P-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            up_q    <= above_mem[col_addr];
            ctr_q   <= ctr_mem[col_addr];
            right_q <= ctr_mem[addr_right];
            o_q     <= old_mem[col_addr];
            v_q     <= vel_mem[col_addr];
            s_q     <= src_mem[col_addr];
        end
        if (cmd.mem_wr)
        begin
            above_mem[col_addr] <= ctr_q;
            ctr_mem[col_addr]   <= cur_reg;
            old_mem[col_addr]   <= old_in_reg;
            vel_mem[col_addr]   <= vel_in_reg;
            src_mem[col_addr]   <= src_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cur_reg    <= cur_pressure;
            old_in_reg <= old_pressure;
            vel_in_reg <= velocity;
            src_in_reg <= source_term;
        end
        if (cmd.mem_wr)
        begin
            sgn_r_reg <= lap_r[LW-1];
            sgn_c_reg <= lap_c[LW-1];
            mag_r_reg <= lap_r[LW-1] ? nlap_r[MW-1:0] : lap_r[MW-1:0];
            mag_c_reg <= lap_c[LW-1] ? nlap_c[MW-1:0] : lap_c[MW-1:0];
            v2_reg    <= V2W'(v_q) * V2W'(v_q);
        end
        if (cmd.coef_en)
        begin
            coef_r_reg <= CW'(v2_reg) * CW'(gain_row);
            coef_c_reg <= CW'(v2_reg) * CW'(gain_col);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PW'(a_chunk) * PW'(b_chunk);
            psel_reg <= cmd.mul_sel;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= pp_neg ? acc_reg - pp_shift : acc_reg + pp_shift;
        end
        if (cmd.fin_en)
        begin
            res_reg <= cmd.res_zero ? '0 : sat;
        end
    end

    // Center value of the previous column; reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (cmd.mem_wr)
        begin
            left_reg <= ctr_q;
        end
    end

    assign new_pressure = res_reg;

endmodule
`default_nettype wire

/* rtl/acoustic_wave_stencil_step_top.sv */
// Acoustic wave stencil step, top level: configuration registers, controller and datapath.
// Accepts a new cell only once the previous one is done: border and interior cells return one
// result word, row-zero cells none, and last-row cells a second, zeroed word; interior cells
// go through the 8-step shared partial-product multiplier.
// Reset (rst_n, asynchronous, active low) loads register defaults and clears the raster position.
// Depends on aws_pkg, aws_ctrl and aws_dp.
`default_nettype none
module acoustic_wave_stencil_step_top #(
    parameter int MAX_COLS      = 512,
    parameter int PRESSURE_BITS = 32,
    parameter int VELOCITY_BITS = 13
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // cur_pressure, old_pressure, velocity, source_term (lowest first), zero padded
    input  wire logic [((3 * PRESSURE_BITS + VELOCITY_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // new_pressure, zero padded
    output logic [((PRESSURE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // end_of_grid
    output logic                                      m_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [aws_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [aws_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import aws_pkg::*;

    localparam int P      = PRESSURE_BITS;
    localparam int V      = VELOCITY_BITS;
    localparam int OUT_W  = ((P + 7) / 8) * 8;
    localparam int ADDR_W = $clog2(MAX_COLS);

    logic [GRID_COLS_W-1:0] grid_cols_reg;
    logic [GRID_ROWS_W-1:0] grid_rows_reg;
    logic [MARGIN_W-1:0]    margin_reg;
    logic [GAIN_W-1:0]      gain_row_reg, gain_col_reg;
    cmd_t                   cmd;
    logic [ADDR_W-1:0]      col_addr;
    logic [P-1:0]           new_pressure;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_COLS_W'(510);
            grid_rows_reg <= GRID_ROWS_W'(510);
            margin_reg    <= MARGIN_W'(5);
            gain_row_reg  <= GAIN_W'(10995);
            gain_col_reg  <= GAIN_W'(10995);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_COLS_W-1:0];
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_ROWS_W-1:0];
                REG_MARGIN:    margin_reg    <= cfg_data[MARGIN_W-1:0];
                REG_GAIN_ROW:  gain_row_reg  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_COL:  gain_col_reg  <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    aws_ctrl #(
        .MAX_COLS(MAX_COLS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .grid_cols    (grid_cols_reg),
        .grid_rows    (grid_rows_reg),
        .border_margin(margin_reg),
        .cmd          (cmd),
        .col_addr     (col_addr)
    );

    aws_dp #(
        .MAX_COLS     (MAX_COLS),
        .PRESSURE_BITS(P),
        .VELOCITY_BITS(V)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .col_addr    (col_addr),
        .cur_pressure(s_tdata[P-1:0]),
        .old_pressure(s_tdata[2*P-1:P]),
        .velocity    (s_tdata[2*P+V-1:2*P]),
        .source_term (s_tdata[3*P+V-1:2*P+V]),
        .gain_row    (gain_row_reg),
        .gain_col    (gain_col_reg),
        .new_pressure(new_pressure)
    );

    assign m_tdata = OUT_W'(new_pressure);

endmodule
`default_nettype wire
